// ===== rtl/udpp_pkg.sv =====
// Package for the UDP header parser: codes, constants and the result record.
`timescale 1ns / 1ps
`default_nettype none

package udpp_pkg;

  // Parse phases
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_HEADER  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;

  // Verdict codes
  localparam logic [2:0] V_ACCEPT    = 3'd0;
  localparam logic [2:0] V_BAD_LINK  = 3'd1;
  localparam logic [2:0] V_NOT_IPV4  = 3'd2;
  localparam logic [2:0] V_BAD_IHL   = 3'd3;
  localparam logic [2:0] V_NOT_UDP   = 3'd4;
  localparam logic [2:0] V_LEN_MISM  = 3'd5;
  localparam logic [2:0] V_TRUNCATED = 3'd6;

  // Result kinds
  localparam logic RK_VERDICT = 1'b0;
  localparam logic RK_PAYLOAD = 1'b1;

  // Link kinds
  localparam logic LK_LOOPBACK = 1'b0;
  localparam logic LK_ETHERNET = 1'b1;

  // Register addresses
  localparam logic [2:0] REG_LINK_KIND = 3'd0;

  localparam logic [15:0] ETH_HDR_LEN   = 16'd14;
  localparam logic [15:0] LOOP_HDR_LEN  = 16'd4;
  localparam logic [15:0] ETH_TYPE_POS  = 16'd12;
  localparam logic [15:0] ETH_TYPE_LAST = 16'd13;
  localparam logic [15:0] LOOP_LAST     = 16'd3;
  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  LOOP_FAMILY   = 8'd2;
  localparam logic [3:0]  IPV4_VERSION  = 4'd4;
  localparam logic [5:0]  IP_HDR_MIN    = 6'd20;
  localparam logic [5:0]  IP_HDR_MAX    = 6'd60;
  localparam logic [15:0] IP_PROTO_POS  = 16'd9;
  localparam logic [7:0]  PROTO_UDP     = 8'd17;
  localparam logic [15:0] UDP_HDR_LEN   = 16'd8;
  localparam logic [15:0] UDP_LEN_HI    = 16'd4;
  localparam logic [15:0] UDP_LEN_LO    = 16'd5;
  localparam logic [15:0] UDP_HDR_LAST  = 16'd7;

  typedef struct packed {
    logic        kind;
    logic [2:0]  verdict;
    logic [15:0] plen;
    logic [7:0]  pbyte;
    logic        plast;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/udp_packet_header_parser_top.sv =====
// Top level of the UDP header parser: byte-stream link, IPv4 and UDP header checks.
// An accepted byte is held in the input register, and its result in the result register.
// Throughput: one byte per cycle while the skid entry is free; each byte needs one compare or field capture against the
// parse state, done in the single stage between the input and result registers.
// A two-entry output buffer holds one extra result while the output stalls, keeping input flowing.
// Reset clears parse state and valid flags and sets link_kind to Ethernet II.
`timescale 1ns / 1ps
`default_nettype none

module udp_packet_header_parser_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  frame_byte_i,
  input  wire logic        frame_start_i,
  input  wire logic        frame_end_i,
  input  wire logic [15:0] captured_length_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             result_kind_o,
  output logic [2:0]       verdict_o,
  output logic [15:0]      payload_length_o,
  output logic [7:0]       payload_byte_o,
  output logic             payload_last_o
);
  import udpp_pkg::*;

  // Configuration
  logic link_kind_q;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready & (paddr == REG_LINK_KIND);
  assign prdata = (paddr == REG_LINK_KIND) ? {31'd0, link_kind_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_kind_q <= LK_ETHERNET;
    end else if (cfg_wr) begin
      link_kind_q <= pwdata[0];
    end
  end

  // Input register
  logic        in_valid_q;
  logic        in_valid_d;
  logic [7:0]  byte_q;
  logic        start_q;
  logic        end_q;
  logic [15:0] caplen_q;
  logic        in_acc;
  logic        proc;

  // Output buffer
  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  res_t main_q, main_d;
  res_t skid_q, skid_d;
  logic pop;
  logic has_res;
  res_t res;

  assign in_stall_o = in_valid_q & skid_valid_q;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign proc       = in_valid_q & ~skid_valid_q;
  assign pop        = out_valid_q & ~out_stall_i;
  assign in_valid_d = in_acc | (in_valid_q & ~proc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      byte_q   <= frame_byte_i;
      start_q  <= frame_start_i;
      end_q    <= frame_end_i;
      caplen_q <= captured_length_i;
    end
  end

  // Parse state
  logic [1:0]  phase_q, phase_d;
  logic [15:0] pos_q, pos_d;
  logic [5:0]  ihl_q, ihl_d;
  logic [15:0] udp_q, udp_d;
  logic [15:0] flen_q, flen_d;
  logic [15:0] lword_q, lword_d;
  logic [15:0] prem_q, prem_d;

  always_comb begin
    logic [1:0]  ph;
    logic [15:0] pos;
    logic [15:0] flen;
    logic [15:0] link_len;
    logic [15:0] r;
    logic [15:0] u;
    logic [15:0] rest;
    logic [15:0] lw;
    logic [5:0]  hl;
    logic        closing;
    logic        decided;
    logic [2:0]  v;
    logic        last;

    // Frame start resets the parse state before the byte is looked at
    ph      = start_q ? PH_HEADER : phase_q;
    pos     = start_q ? 16'd0 : pos_q;
    flen    = start_q ? caplen_q : flen_q;
    ihl_d   = start_q ? 6'd0 : ihl_q;
    udp_d   = start_q ? 16'd0 : udp_q;
    lword_d = start_q ? 16'd0 : lword_q;
    prem_d  = start_q ? 16'd0 : prem_q;
    phase_d = ph;
    pos_d   = pos;
    flen_d  = flen;

    link_len = (link_kind_q == LK_ETHERNET) ? ETH_HDR_LEN : LOOP_HDR_LEN;
    r        = pos - link_len;
    u        = r - {10'd0, ihl_d};
    rest     = flen - pos - 16'd1;
    hl       = {byte_q[3:0], 2'b00};
    lw       = 16'd0;
    closing  = 1'b0;
    decided  = 1'b0;
    v        = V_TRUNCATED;
    last     = 1'b0;

    has_res = 1'b0;
    res     = '0;

    unique case (ph)
      PH_PAYLOAD: begin
        last        = (prem_d <= 16'd1) | end_q;
        has_res     = 1'b1;
        res.kind    = RK_PAYLOAD;
        res.pbyte   = byte_q;
        res.plast   = last;
        if (last) begin
          prem_d  = 16'd0;
          phase_d = PH_IDLE;
        end else begin
          prem_d = prem_d - 16'd1;
        end
      end
      PH_HEADER: begin
        if (pos >= flen) begin
          decided = 1'b1;
          v       = V_TRUNCATED;
        end else begin
          closing = end_q | ({1'b0, pos} + 17'd1 >= {1'b0, flen});
          pos_d   = pos + 16'd1;
          if (pos < link_len) begin
            if (link_kind_q == LK_ETHERNET) begin
              lw = {lword_d[7:0], byte_q};
              if (pos >= ETH_TYPE_POS) begin
                lword_d = lw;
              end
              if (pos == ETH_TYPE_LAST) begin
                decided = (lw != ETH_TYPE_IPV4);
                v       = V_BAD_LINK;
              end
            end else begin
              lw      = lword_d | {8'd0, (pos == 16'd0) ? (byte_q ^ LOOP_FAMILY) : byte_q};
              lword_d = lw;
              if (pos == LOOP_LAST) begin
                decided = (lw != 16'd0);
                v       = V_BAD_LINK;
              end
            end
          end else if (r == 16'd0) begin
            if (byte_q[7:4] != IPV4_VERSION) begin
              decided = 1'b1;
              v       = V_NOT_IPV4;
            end else if (hl < IP_HDR_MIN || hl > IP_HDR_MAX) begin
              decided = 1'b1;
              v       = V_BAD_IHL;
            end else begin
              ihl_d = hl;
            end
          end else if (r == IP_PROTO_POS) begin
            decided = (byte_q != PROTO_UDP);
            v       = V_NOT_UDP;
          end else if (r >= {10'd0, ihl_d}) begin
            if (u == UDP_LEN_HI) begin
              udp_d = {byte_q, 8'd0};
            end else if (u == UDP_LEN_LO) begin
              udp_d = {udp_d[15:8], byte_q};
            end else if (u == UDP_HDR_LAST) begin
              decided = 1'b1;
              if (udp_d >= UDP_HDR_LEN && (udp_d - UDP_HDR_LEN) == rest) begin
                prem_d = rest;
                v      = V_ACCEPT;
              end else begin
                v = V_LEN_MISM;
              end
            end
          end
          if (!decided) begin
            decided = closing;
            v       = V_TRUNCATED;
          end else if (v == V_ACCEPT && prem_d != 16'd0 && end_q) begin
            v = V_TRUNCATED;
          end
        end
        if (decided) begin
          has_res     = 1'b1;
          res.kind    = RK_VERDICT;
          res.verdict = v;
          if (v == V_ACCEPT && prem_d != 16'd0) begin
            res.plen = prem_d;
            phase_d  = PH_PAYLOAD;
          end else begin
            prem_d  = 16'd0;
            phase_d = PH_IDLE;
          end
        end
      end
      default: begin
        // idle or unused code: drop stray bytes
        phase_d = ph;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      pos_q   <= 16'd0;
      ihl_q   <= 6'd0;
      udp_q   <= 16'd0;
      flen_q  <= 16'd0;
      lword_q <= 16'd0;
      prem_q  <= 16'd0;
    end else if (proc) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      ihl_q   <= ihl_d;
      udp_q   <= udp_d;
      flen_q  <= flen_d;
      lword_q <= lword_d;
      prem_q  <= prem_d;
    end
  end

  // Output buffer: main register plus one skid entry
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (pop) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (proc && has_res) begin
      if (out_valid_q && !pop) begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end else begin
        main_d      = res;
        out_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign out_valid_o      = out_valid_q;
  assign result_kind_o    = main_q.kind;
  assign verdict_o        = main_q.verdict;
  assign payload_length_o = main_q.plen;
  assign payload_byte_o   = main_q.pbyte;
  assign payload_last_o   = main_q.plast;

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for the UDP header parser: frame stimulus, byte-level prediction, checks.
`timescale 1ns / 1ps

module tb;
  import udpp_pkg::*;

  localparam logic [2:0] V_NONE = 3'd7;   // header byte left the verdict open
  localparam int PHASE_ITEMS = 260;
  localparam int HOLD_CYCLES = 200;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [7:0]  data;
    logic        sof;
    logic        eof;
    logic [15:0] caplen;
  } frame_item_t;

  typedef enum int {
    F_NONE, F_LINK, F_VERSION, F_IHL, F_PROTO, F_LEN, F_UDP_SHORT, F_CUT, F_END_EARLY,
    F_HDR_END, F_PAYLOAD_END, F_ZERO_LEN, F_RESTART, F_HUGE, F_OVERRUN
  } fault_e;

  class udp_parse_tracker;
    logic        link_kind;
    logic [1:0]  phase;
    int unsigned pos, ihl_bytes, udp_len, frame_len, link_acc, remaining;
    res_t        due_results[$];
    int          errors;

    function new();
      link_kind = LK_ETHERNET;
      phase = PH_IDLE;
      pos = 0;
      ihl_bytes = 0;
      udp_len = 0;
      frame_len = 0;
      link_acc = 0;
      remaining = 0;
      errors = 0;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // Walk one header byte through the link, IPv4 and UDP checks.
    function logic [2:0] header_check(int unsigned p, logic [7:0] b);
      int unsigned hdr_len, r, u, rest, hl;
      hdr_len = (link_kind == LK_ETHERNET) ? ETH_HDR_LEN : LOOP_HDR_LEN;
      if (p < hdr_len) begin
        if (link_kind == LK_ETHERNET) begin
          if (p >= ETH_TYPE_POS) link_acc = ((link_acc << 8) | b) & 16'hFFFF;
          if (p == ETH_TYPE_LAST) return (link_acc != ETH_TYPE_IPV4) ? V_BAD_LINK : V_NONE;
        end else begin
          // any bit left over after the family xor marks a bad word
          link_acc = (link_acc | ((p == 0) ? (b ^ LOOP_FAMILY) : b)) & 16'hFFFF;
          if (p == LOOP_LAST) return (link_acc != 0) ? V_BAD_LINK : V_NONE;
        end
        return V_NONE;
      end
      r = p - hdr_len;
      if (r == 0) begin
        hl = b[3:0] * 4;
        if (b[7:4] != IPV4_VERSION) return V_NOT_IPV4;
        if (hl < IP_HDR_MIN || hl > IP_HDR_MAX) return V_BAD_IHL;
        ihl_bytes = hl;
        return V_NONE;
      end
      if (r == IP_PROTO_POS) return (b != PROTO_UDP) ? V_NOT_UDP : V_NONE;
      if (r < ihl_bytes) return V_NONE;
      u = r - ihl_bytes;
      if (u == UDP_LEN_HI) begin
        udp_len = {b, 8'h00};
      end else if (u == UDP_LEN_LO) begin
        udp_len = udp_len | b;
      end else if (u == UDP_HDR_LAST) begin
        rest = frame_len - (p + 1);
        if (udp_len >= UDP_HDR_LEN && udp_len - UDP_HDR_LEN == rest) begin
          remaining = rest;
          return V_ACCEPT;
        end
        return V_LEN_MISM;
      end
      return V_NONE;
    endfunction

    function void note_byte(frame_item_t it);
      res_t        r;
      logic [2:0]  v;
      int unsigned p;
      bit          closing, is_last;
      r = '0;
      if (it.sof) begin
        phase = PH_HEADER;
        pos = 0;
        frame_len = it.caplen;
        ihl_bytes = 0;
        udp_len = 0;
        link_acc = 0;
        remaining = 0;
      end
      if (phase == PH_PAYLOAD) begin
        is_last = (remaining <= 1) || it.eof;
        r.kind = RK_PAYLOAD;
        r.pbyte = it.data;
        r.plast = is_last;
        remaining = (remaining - 1) & 16'hFFFF;
        if (is_last) begin
          remaining = 0;
          phase = PH_IDLE;
        end
        due_results.insert(due_results.size(), r);
        return;
      end
      if (phase != PH_HEADER) return;
      p = pos;
      if (p >= frame_len) begin
        v = V_TRUNCATED;
      end else begin
        closing = it.eof || (p + 1 >= frame_len);
        v = header_check(p, it.data);
        pos = (p + 1) & 16'hFFFF;
        if (v == V_NONE) begin
          if (!closing) return;
          v = V_TRUNCATED;
        end else if (v == V_ACCEPT && remaining != 0 && it.eof) begin
          v = V_TRUNCATED;
        end
      end
      r.kind = RK_VERDICT;
      r.verdict = v;
      if (v == V_ACCEPT && remaining != 0) begin
        r.plen = remaining[15:0];
        phase = PH_PAYLOAD;
      end else begin
        remaining = 0;
        phase = PH_IDLE;
      end
      due_results.insert(due_results.size(), r);
    endfunction

    function string describe(res_t r);
      return $sformatf("kind=%0d verdict=%0d plen=%0d byte=%02h last=%0d",
                       r.kind, r.verdict, r.plen, r.pbyte, r.plast);
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("%s", msg);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (due_results.size() == 0) begin
        flag($sformatf("result with nothing due: %s", describe(got)));
        return;
      end
      want = due_results.pop_front();
      if (got.kind !== want.kind || got.verdict !== want.verdict || got.plen !== want.plen ||
          got.pbyte !== want.pbyte || got.plast !== want.plast)
        flag($sformatf("mismatch: expected %s, got %s", describe(want), describe(got)));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  frame_byte_i;
  logic        frame_start_i;
  logic        frame_end_i;
  logic [15:0] captured_length_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        result_kind_o;
  logic [2:0]  verdict_o;
  logic [15:0] payload_length_o;
  logic [7:0]  payload_byte_o;
  logic        payload_last_o;

  udp_parse_tracker tracker;
  frame_item_t      stim_q[$];
  int               tx_idle_pct = 0;
  int               rx_idle_pct = 0;
  bit               hold_go = 1'b0;
  logic             hold_on = 1'b0;

  udp_packet_header_parser_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .frame_byte_i     (frame_byte_i),
    .frame_start_i    (frame_start_i),
    .frame_end_i      (frame_end_i),
    .captured_length_i(captured_length_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_kind_o    (result_kind_o),
    .verdict_o        (verdict_o),
    .payload_length_o (payload_length_o),
    .payload_byte_o   (payload_byte_o),
    .payload_last_o   (payload_last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Long receiver hold-off so the parser backs up and stalls its input.
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= hold_on || ($urandom_range(99) < rx_idle_pct);
  end

  always @(posedge clk_i) begin
    if (out_valid_o === 1'b1 && out_stall_i === 1'b0)
      tracker.check_result({result_kind_o, verdict_o, payload_length_o, payload_byte_o,
                            payload_last_o});
  end

  function automatic int queue_frame(logic lk, fault_e f, int plen, int ihl_sel);
    logic [7:0]  fb[$];
    logic [3:0]  ver, ihl_nib;
    logic [7:0]  proto;
    logic [15:0] caplen, ulen;
    int          words, total, hdr_total, send_n, eof_at, k;
    frame_item_t it;
    if ((f == F_HDR_END || f == F_PAYLOAD_END) && plen < 2) plen = 2;
    if (lk == LK_ETHERNET) begin
      repeat (12) fb.insert(fb.size(), 8'($urandom));
      fb.insert(fb.size(), ETH_TYPE_IPV4[15:8]);
      fb.insert(fb.size(), ETH_TYPE_IPV4[7:0]);
    end else begin
      fb.insert(fb.size(), LOOP_FAMILY);
      repeat (3) fb.insert(fb.size(), 8'h00);
    end
    if (f == F_LINK) begin
      k = (lk == LK_ETHERNET) ? $urandom_range(13, 12) : $urandom_range(3, 0);
      fb[k] = fb[k] ^ 8'($urandom_range(255, 1));
    end
    ver = IPV4_VERSION;
    if (f == F_VERSION) begin
      ver = 4'($urandom_range(14));
      if (ver >= IPV4_VERSION) ver++;
    end
    if (ihl_sel > 0) ihl_nib = 4'(ihl_sel);
    else ihl_nib = ($urandom_range(3) == 0) ? 4'($urandom_range(15, 6)) : 4'd5;
    if (f == F_IHL) ihl_nib = 4'($urandom_range(4));
    words = (ihl_nib < 5) ? 5 : ihl_nib;
    proto = PROTO_UDP;
    if (f == F_PROTO) begin
      proto = 8'($urandom_range(254));
      if (proto >= PROTO_UDP) proto++;
    end
    fb.insert(fb.size(), {ver, ihl_nib});
    for (int i = 1; i < 4 * words; i++)
      fb.insert(fb.size(), (i == IP_PROTO_POS) ? proto : 8'($urandom));
    ulen = 16'(plen + 8);
    if (f == F_LEN) begin
      do ulen = 16'($urandom_range(65535, 8)); while (ulen == 16'(plen + 8));
    end
    if (f == F_UDP_SHORT) ulen = 16'($urandom_range(7));
    repeat (4) fb.insert(fb.size(), 8'($urandom));
    fb.insert(fb.size(), ulen[15:8]);
    fb.insert(fb.size(), ulen[7:0]);
    repeat (2) fb.insert(fb.size(), 8'($urandom));
    hdr_total = fb.size();
    repeat (plen) fb.insert(fb.size(), 8'($urandom));
    total = fb.size();
    caplen = 16'(total);
    send_n = total;
    eof_at = $urandom_range(1) ? total - 1 : -1;
    case (f)
      F_CUT: begin
        caplen = 16'($urandom_range(hdr_total - 1, 1));
        send_n = caplen + $urandom_range(2);
        if (send_n > total) send_n = total;
        eof_at = $urandom_range(1) ? caplen - 1 : -1;
      end
      F_END_EARLY: begin
        eof_at = $urandom_range(hdr_total - 2);
        send_n = eof_at + 1;
      end
      F_HDR_END: begin
        eof_at = hdr_total - 1;
        send_n = hdr_total;
      end
      F_PAYLOAD_END: begin
        eof_at = $urandom_range(total - 2, hdr_total);
        send_n = eof_at + 1;
      end
      F_ZERO_LEN: begin
        caplen = '0;
        send_n = $urandom_range(4, 1);
        eof_at = -1;
      end
      F_RESTART: begin
        send_n = $urandom_range(total - 1, 1);
        eof_at = -1;
      end
      F_HUGE: begin
        caplen = $urandom_range(1) ? 16'hFFFF : 16'($urandom_range(65535, total + 1));
        send_n = hdr_total + $urandom_range(3);
        if (send_n > total) send_n = total;
        eof_at = -1;
      end
      F_OVERRUN: begin
        // spill stray bytes past the captured length
        repeat ($urandom_range(4, 1)) fb.insert(fb.size(), 8'($urandom));
        send_n = fb.size();
        eof_at = $urandom_range(1) ? send_n - 1 : -1;
      end
      default: ;
    endcase
    for (int i = 0; i < send_n; i++) begin
      it.data = fb[i];
      it.sof = (i == 0);
      it.eof = (i == eof_at);
      it.caplen = (i == 0) ? caplen : 16'($urandom);
      stim_q.insert(stim_q.size(), it);
    end
    return send_n;
  endfunction

  function automatic void queue_noise();
    frame_item_t it;
    repeat ($urandom_range(3, 1)) begin
      it.data = 8'($urandom);
      it.sof = 1'b0;
      it.eof = 1'($urandom);
      it.caplen = 16'($urandom);
      stim_q.insert(stim_q.size(), it);
    end
  endfunction

  task automatic write_link_kind(logic kind);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_LINK_KIND;
    pwdata <= {31'd0, kind};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tracker.link_kind = kind;
  endtask

  task automatic play_queue();
    frame_item_t it;
    while (stim_q.size() > 0) begin
      it = stim_q.pop_front();
      while ($urandom_range(99) < tx_idle_pct) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      frame_byte_i <= it.data;
      frame_start_i <= it.sof;
      frame_end_i <= it.eof;
      captured_length_i <= it.caplen;
      do @(posedge clk_i); while (in_stall_o !== 1'b0);
      tracker.note_byte(it);
    end
    in_valid_i <= 1'b0;
  endtask

  // Hold until every due result is back, then let the pipeline empty.
  task automatic settle();
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int     made;
    fault_e f;
    logic   lk;
    int     plen;
    tracker = new();
    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid_i <= 1'b0;
    frame_byte_i <= '0;
    frame_start_i <= 1'b0;
    frame_end_i <= 1'b0;
    captured_length_i <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_link_kind(LK_ETHERNET);
    queue_noise();
    void'(queue_frame(LK_ETHERNET, F_NONE, 1, 0));
    void'(queue_frame(LK_ETHERNET, F_LINK, 0, 0));
    void'(queue_frame(LK_ETHERNET, F_ZERO_LEN, 0, 0));
    void'(queue_frame(LK_ETHERNET, F_HUGE, 0, 0));
    void'(queue_frame(LK_ETHERNET, F_NONE, 4, 15));
    play_queue();
    settle();

    write_link_kind(LK_LOOPBACK);
    void'(queue_frame(LK_LOOPBACK, F_NONE, 0, 5));
    void'(queue_frame(LK_LOOPBACK, F_LINK, 0, 0));
    void'(queue_frame(LK_LOOPBACK, F_VERSION, 0, 0));
    void'(queue_frame(LK_LOOPBACK, F_IHL, 0, 0));
    void'(queue_frame(LK_LOOPBACK, F_PROTO, 0, 0));
    void'(queue_frame(LK_LOOPBACK, F_LEN, 2, 0));
    void'(queue_frame(LK_LOOPBACK, F_UDP_SHORT, 0, 0));
    void'(queue_frame(LK_LOOPBACK, F_CUT, 3, 0));
    void'(queue_frame(LK_LOOPBACK, F_END_EARLY, 3, 0));
    void'(queue_frame(LK_LOOPBACK, F_HDR_END, 3, 0));
    void'(queue_frame(LK_LOOPBACK, F_PAYLOAD_END, 5, 0));
    void'(queue_frame(LK_LOOPBACK, F_RESTART, 4, 0));
    void'(queue_frame(LK_LOOPBACK, F_OVERRUN, 2, 0));
    void'(queue_frame(LK_LOOPBACK, F_NONE, 2, 5));
    play_queue();
    settle();

    for (int p = 0; p < 3; p++) begin
      tx_idle_pct = (p == 0) ? 12 : (p == 1) ? 87 : 0;
      rx_idle_pct = (p == 0) ? 87 : (p == 1) ? 12 : 0;
      lk = (p == 1) ? LK_ETHERNET : LK_LOOPBACK;
      write_link_kind(lk);
      made = 0;
      while (made < PHASE_ITEMS) begin
        f = ($urandom_range(99) < 55) ? F_NONE : fault_e'($urandom_range(F_OVERRUN, F_LINK));
        plen = ($urandom_range(19) == 0) ? $urandom_range(200) : $urandom_range(24);
        made += queue_frame(lk, f, plen, 0);
        if ($urandom_range(19) == 0) queue_noise();
      end
      if (p == 2) hold_go = 1'b1;
      play_queue();
      settle();
    end

    repeat (10) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
